// File: design/tbvm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the tiny byte-coded machine.
// Holds command codes, run status, sequencer states and instruction opcodes; no dependencies.
package tbvm_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_HALT    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_OPCODE,
    S_ARG1,
    S_ARG2,
    S_READ,
    S_LOAD_LO,
    S_LOAD_HI,
    S_STORE_HI,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WRAP_ITEM,
    WRAP_PC,
    WRAP_OPND
  } wrap_t;

  localparam logic [7:0] OP_NOOP   = 8'h00;
  localparam logic [7:0] OP_LOADW  = 8'h01;
  localparam logic [7:0] OP_STOREW = 8'h02;
  localparam logic [7:0] OP_ADD    = 8'h03;
  localparam logic [7:0] OP_SUB    = 8'h04;
  localparam logic [7:0] OP_ADDI   = 8'h05;
  localparam logic [7:0] OP_SUBI   = 8'h06;
  localparam logic [7:0] OP_JUMP   = 8'h07;
  localparam logic [7:0] OP_BEQZ   = 8'h08;
  localparam logic [7:0] OP_HALT   = 8'hff;

  localparam logic [1:0] REG_PC  = 2'd0;
  localparam logic [1:0] REG_ONE = 2'd1;

  localparam logic [7:0]  LAST_REG   = 8'd2;
  localparam logic [15:0] INSN_BYTES = 16'd3;

endpackage

// File: design/tbvm_cmd_if.sv
`timescale 1ns / 1ps
// Command channel of the tiny byte-coded machine: valid/ready handshake with item fields.
// No dependencies.
interface tbvm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] address;
  logic [7:0] write_byte;

  modport source (output valid, opcode, address, write_byte, input ready);
  modport sink   (input valid, opcode, address, write_byte, output ready);
endinterface

// File: design/tbvm_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the tiny byte-coded machine: valid/ready handshake with result fields.
// No dependencies.
interface tbvm_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] program_counter;
  logic [15:0] reg_one;
  logic [15:0] reg_two;
  logic [7:0]  read_byte;
  logic [1:0]  run_status;

  modport source (output valid, program_counter, reg_one, reg_two, read_byte, run_status,
                  input ready);
  modport sink   (input valid, program_counter, reg_one, reg_two, read_byte, run_status,
                  output ready);
endinterface

// File: design/tbvm_wrap.sv
`timescale 1ns / 1ps
// Two-stage unit that reduces a 16-bit address modulo MEM_BYTES by a reciprocal multiply.
// No dependencies.
module tbvm_wrap #(
  parameter int MEM_BYTES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [15:0]                  x,
  output logic                         done,
  output logic [$clog2(MEM_BYTES)-1:0] rem
);
  localparam int          AW    = $clog2(MEM_BYTES);
  localparam int          SHIFT = 24;
  localparam int unsigned RECIP = (2 ** SHIFT) / MEM_BYTES + 1;
  localparam int          RW    = $clog2(RECIP + 1);
  localparam int          PW    = 16 + RW;

  logic [PW-1:0] prod;
  logic [15:0]   x_q;
  logic          v1;
  logic [15:0]   quot;
  logic [15:0]   diff;

  assign quot = 16'(prod[PW-1:SHIFT]);
  assign diff = x_q - quot * 16'(MEM_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q  <= x;
      prod <= PW'(x) * PW'(RECIP);
    end
    if (v1) begin
      rem <= diff[AW-1:0];
    end
  end
endmodule

// File: design/tbvm_ram.sv
`timescale 1ns / 1ps
// Byte memory with one write port and one registered read port.
// No dependencies.
module tbvm_ram #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: design/tiny_byte_vm_step.sv
`timescale 1ns / 1ps
// Top level of the tiny byte-coded machine: command sequencer, register file and result register.
// Depends on tbvm_pkg, tbvm_cmd_if, tbvm_rsp_if, tbvm_wrap and tbvm_ram.
//
//   Channel  Dir  Carries
//   cmd      in   opcode, address, write_byte
//   rsp      out  program_counter, reg_one, reg_two, read_byte, run_status
//
// From acceptance to result, a write, a clear or a step while stopped goes straight to S_DONE, a
// read through S_READ, NOOP, HALT and an unknown opcode through S_OPCODE, JUMP through S_ARG1,
// an arithmetic or branch step or a bad register index through S_ARG2, STOREW through S_STORE_HI
// and LOADW through S_LOAD_LO and S_LOAD_HI, with at most one byte-wide memory access per state;
// an address at or above MEM_BYTES first passes through S_WRAP and the modulo unit.
// The next transaction is taken in the cycle the result moves to the output register.
// Reset clears registers, status and handshake state; memory is undefined until written.
module tiny_byte_vm_step #(
  parameter int MEM_BYTES = 256
) (
  input logic        clk,
  input logic        rst,
  tbvm_cmd_if.sink   cmd,
  tbvm_rsp_if.source rsp
);
  import tbvm_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    n = (p == AW'(MEM_BYTES - 1)) ? '0 : p + AW'(1);
    return n;
  endfunction

  function automatic logic [15:0] reg_sel(input logic [1:0] idx, input logic [15:0] r0v,
                                          input logic [15:0] r1v, input logic [15:0] r2v);
    logic [15:0] v;
    case (idx)
      REG_PC:  v = r0v;
      REG_ONE: v = r1v;
      default: v = r2v;
    endcase
    return v;
  endfunction

  state_t        state, state_next, disp_state;
  status_t       status, status_next;
  logic [15:0]   pc, pc_next, r1, r1_next, r2, r2_next;
  logic [7:0]    op_q, op_next, a1_q, a1_next, lo_q, lo_next, rb, rb_next;
  logic [AW-1:0] ptr, ptr_next;
  cmd_t          item_op, item_op_next, disp_cmd;
  logic [7:0]    item_wb, item_wb_next, disp_wb;
  wrap_t         wrap_for, wrap_for_next, mod_for, disp_for;

  logic          start, out_free;
  logic          disp_en, mod_start, mod_done;
  logic [AW-1:0] disp_addr, mod_rem;
  logic [15:0]   mod_x;
  logic          addr_fits, pc_fits, arg_fits, arg_ok;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic          wb_en;
  logic [1:0]    wb_idx;
  logic [15:0]   wb_val, src_a, src_b, imm;

  logic          out_valid;
  logic [15:0]   out_pc, out_r1, out_r2;
  logic [7:0]    out_rb;
  logic [1:0]    out_status;

  tbvm_ram #(.DEPTH(MEM_BYTES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tbvm_wrap #(.MEM_BYTES(MEM_BYTES)) u_wrap (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .x     (mod_x),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign out_free  = !out_valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) || (state == S_DONE && out_free);
  assign start     = cmd.valid && cmd.ready;

  assign addr_fits = {8'h00, cmd.address} < 16'(MEM_BYTES);
  assign pc_fits   = pc < 16'(MEM_BYTES);
  assign arg_fits  = {8'h00, mem_rdata} < 16'(MEM_BYTES);
  assign arg_ok    = (a1_q <= LAST_REG) &&
                     !((op_q == OP_ADD || op_q == OP_SUB) && mem_rdata > LAST_REG);

  assign disp_cmd  = start ? cmd_t'(cmd.opcode) : item_op;
  assign disp_wb   = start ? cmd.write_byte : item_wb;

  always_comb begin : ctrl
    disp_en   = 1'b0;
    disp_for  = WRAP_ITEM;
    disp_addr = '0;
    mod_start = 1'b0;
    mod_for   = WRAP_ITEM;
    mod_x     = '0;
    if (start) begin
      unique case (cmd.opcode) inside
        CMD_WRITE, CMD_READ: begin
          if (addr_fits) begin
            disp_en   = 1'b1;
            disp_addr = cmd.address[AW-1:0];
          end else begin
            mod_start = 1'b1;
            mod_x     = {8'h00, cmd.address};
          end
        end
        CMD_STEP: begin
          if (status == ST_RUN) begin
            if (pc_fits) begin
              disp_en   = 1'b1;
              disp_for  = WRAP_PC;
              disp_addr = pc[AW-1:0];
            end else begin
              mod_start = 1'b1;
              mod_for   = WRAP_PC;
              mod_x     = pc;
            end
          end
        end
        default: ;
      endcase
    end
    if (state == S_WRAP && mod_done) begin
      disp_en   = 1'b1;
      disp_for  = wrap_for;
      disp_addr = mod_rem;
    end
    if (state == S_ARG2 && arg_ok && (op_q == OP_LOADW || op_q == OP_STOREW)) begin
      if (arg_fits) begin
        disp_en   = 1'b1;
        disp_for  = WRAP_OPND;
        disp_addr = mem_rdata[AW-1:0];
      end else begin
        mod_start = 1'b1;
        mod_for   = WRAP_OPND;
        mod_x     = {8'h00, mem_rdata};
      end
    end
  end

  always_comb begin : disp_decode
    unique case (disp_for)
      WRAP_ITEM: disp_state = (disp_cmd == CMD_WRITE) ? S_DONE : S_READ;
      WRAP_PC:   disp_state = S_OPCODE;
      default:   disp_state = (op_q == OP_LOADW) ? S_LOAD_LO : S_STORE_HI;
    endcase
  end

  always_comb begin : next_state
    state_next = state;
    if (disp_en) begin
      state_next = disp_state;
    end else if (mod_start) begin
      state_next = S_WRAP;
    end else begin
      unique case (state)
        S_IDLE:    state_next = start ? S_DONE : S_IDLE;
        S_DONE: begin
          if (start) begin
            state_next = S_DONE;
          end else if (out_free) begin
            state_next = S_IDLE;
          end
        end
        S_WRAP:    state_next = S_WRAP;
        S_OPCODE: begin
          unique case (mem_rdata) inside
            OP_HALT, OP_NOOP: state_next = S_DONE;
            default:          state_next = (mem_rdata > OP_BEQZ) ? S_DONE : S_ARG1;
          endcase
        end
        S_ARG1:    state_next = (op_q == OP_JUMP) ? S_DONE : S_ARG2;
        S_LOAD_LO: state_next = S_LOAD_HI;
        default:   state_next = S_DONE;
      endcase
    end
  end

  always_comb begin : datapath
    pc_next       = pc;
    r1_next       = r1;
    r2_next       = r2;
    status_next   = status;
    op_next       = op_q;
    a1_next       = a1_q;
    lo_next       = lo_q;
    ptr_next      = ptr;
    rb_next       = rb;
    item_op_next  = item_op;
    item_wb_next  = item_wb;
    wrap_for_next = wrap_for;
    mem_we        = 1'b0;
    mem_waddr     = disp_addr;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = disp_addr;
    wb_en         = 1'b0;
    wb_idx        = a1_q[1:0];
    wb_val        = '0;
    src_a         = reg_sel(a1_q[1:0], pc, r1, r2);
    src_b         = reg_sel(mem_rdata[1:0], pc, r1, r2);
    imm           = {8'h00, mem_rdata};

    if (start) begin
      item_op_next = cmd_t'(cmd.opcode);
      item_wb_next = cmd.write_byte;
      rb_next      = '0;
      if (cmd.opcode == CMD_CLEAR) begin
        pc_next     = '0;
        r1_next     = '0;
        r2_next     = '0;
        status_next = ST_RUN;
      end
    end
    if (mod_start) begin
      wrap_for_next = mod_for;
    end

    case (state)
      S_OPCODE: begin
        op_next   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = wrap_inc(ptr);
        if (mem_rdata == OP_HALT) begin
          status_next = ST_HALT;
        end else if (mem_rdata == OP_NOOP) begin
          pc_next = pc + 16'd1;
        end else if (mem_rdata > OP_BEQZ) begin
          status_next = ST_ILLEGAL;
        end
      end
      S_ARG1: begin
        a1_next   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = wrap_inc(wrap_inc(ptr));
        if (op_q == OP_JUMP) begin
          pc_next = {8'h00, mem_rdata};
        end
      end
      S_ARG2: begin
        if (!arg_ok) begin
          status_next = ST_ILLEGAL;
        end else begin
          case (op_q)
            OP_ADD:  begin wb_en = 1'b1; wb_val = src_a + src_b; end
            OP_SUB:  begin wb_en = 1'b1; wb_val = src_a - src_b; end
            OP_ADDI: begin wb_en = 1'b1; wb_val = src_a + imm;   end
            OP_SUBI: begin wb_en = 1'b1; wb_val = src_a - imm;   end
            OP_BEQZ: begin
              wb_en  = 1'b1;
              wb_idx = REG_PC;
              wb_val = (src_a == 16'd0) ? pc + imm : pc;
            end
            default: ;
          endcase
        end
      end
      S_READ: rb_next = mem_rdata;
      S_LOAD_LO: begin
        lo_next   = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = wrap_inc(ptr);
      end
      S_LOAD_HI: begin
        wb_en  = 1'b1;
        wb_val = {mem_rdata, lo_q};
      end
      S_STORE_HI: begin
        mem_we    = 1'b1;
        mem_waddr = wrap_inc(ptr);
        mem_wdata = src_a[15:8];
        pc_next   = pc + INSN_BYTES;
      end
      default: ;
    endcase

    if (disp_en) begin
      unique case (disp_for)
        WRAP_ITEM: begin
          if (disp_cmd == CMD_WRITE) begin
            mem_we    = 1'b1;
            mem_wdata = disp_wb;
          end else begin
            mem_re = 1'b1;
          end
        end
        WRAP_PC: begin
          mem_re   = 1'b1;
          ptr_next = disp_addr;
        end
        default: begin
          ptr_next = disp_addr;
          if (op_q == OP_LOADW) begin
            mem_re = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = src_a[7:0];
          end
        end
      endcase
    end

    if (wb_en) begin
      case (wb_idx)
        REG_PC: pc_next = wb_val + INSN_BYTES;
        REG_ONE: begin
          r1_next = wb_val;
          pc_next = pc + INSN_BYTES;
        end
        default: begin
          r2_next = wb_val;
          pc_next = pc + INSN_BYTES;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_RUN;
      pc     <= '0;
      r1     <= '0;
      r2     <= '0;
    end else begin
      state  <= state_next;
      status <= status_next;
      pc     <= pc_next;
      r1     <= r1_next;
      r2     <= r2_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_next;
    a1_q     <= a1_next;
    lo_q     <= lo_next;
    ptr      <= ptr_next;
    rb       <= rb_next;
    item_op  <= item_op_next;
    item_wb  <= item_wb_next;
    wrap_for <= wrap_for_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_pc     <= pc;
      out_r1     <= r1;
      out_r2     <= r2;
      out_rb     <= rb;
      out_status <= status;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.program_counter = out_pc;
  assign rsp.reg_one         = out_r1;
  assign rsp.reg_two         = out_r2;
  assign rsp.read_byte       = out_rb;
  assign rsp.run_status      = out_status;
endmodule

// File: design/tbvm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the tiny byte-coded machine, bound to the top level.
// Depends on the tiny_byte_vm_step top level for the bind.
module tbvm_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_pc
);
  logic [1:0] pending;
  logic       cmd_fire;
  logic       rsp_fire;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(cmd_fire) - 2'(rsp_fire);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without an outstanding transaction");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    cmd_ready |-> (pending != 2'd2 || rsp_ready))
    else $error("command taken with two transactions outstanding");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pc))
    else $error("stalled result changed");
endmodule

bind tiny_byte_vm_step tbvm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_pc    (rsp.program_counter)
);
